/* design/c2dc_pkg.sv */
// Shared types, constants and the ROM builder for the dry-air CO2 compensation block.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps

package c2dc_pkg;

	typedef longint unsigned u64_t;

	// Field widths.
	localparam int CO2_W  = 19;
	localparam int TEMP_W = 15;
	localparam int HUM_W  = 14;
	localparam int THR_W  = 16;
	localparam int CFG_W  = 19;
	localparam int IDX_W  = 3;
	localparam int OUT_W  = 16;
	localparam int OUT_MAX = 65535;

	// Vapour ratio ROM geometry.
	localparam int TABLE_ENTRIES = 1024;
	localparam int ADDR_W = $clog2(TABLE_ENTRIES);
	localparam int LAST_ENTRY = TABLE_ENTRIES - 1;
	localparam int TSTEP = (32767 + TABLE_ENTRIES - 2) / (TABLE_ENTRIES - 1);
	localparam int TSTEP_HALF = TSTEP / 2;
	localparam int F_W = $clog2(TSTEP);
	localparam int ROM_W = 32;
	localparam int OFF_W = 15;

	// Node index by reciprocal: off * RECIP_T >> T_SHIFT, then one correction.
	localparam int T_SHIFT = 32;
	localparam u64_t RECIP_T = (u64_t'(1) << T_SHIFT) / u64_t'(TSTEP);
	localparam int TP_W = OFF_W + T_SHIFT;

	// Interpolation quotient by reciprocal, split into two partial products.
	localparam int V_W = ROM_W + F_W;
	localparam int LO_W = V_W / 2;
	localparam int HI_W = V_W - LO_W;
	localparam int S_I = ROM_W + F_W - 1;
	localparam u64_t RECIP_I = (u64_t'(1) << S_I) / u64_t'(TSTEP);
	localparam int SUM_W = V_W + ROM_W;
	localparam int R_W = F_W + 2;

	// Mole fraction: round(x * h / 10000), clamped to 0.08 in Q24.
	localparam int HUM_MAX = 10000;
	localparam int HUM_HALF = 5000;
	localparam int P_W = ROM_W + HUM_W;
	localparam int XMAX_Q24 = 1342177;
	localparam int M_W = 21;
	localparam u64_t SAT_LIM = u64_t'(XMAX_Q24 + 1) * u64_t'(HUM_MAX);
	localparam int Y_W = 30;
	localparam int M_DIV = 625;
	localparam int M_SHIFT = 40;
	localparam int RM_W = 31;
	localparam u64_t RECIP_M = (u64_t'(1) << M_SHIFT) / u64_t'(M_DIV);
	localparam int MR_W = 11;
	localparam int MP_W = Y_W + RM_W;

	// Divider operands.
	localparam int ONE_Q24 = 1 << 24;
	localparam int DEN_W = 28;
	localparam int N_W = 45;
	localparam int D_W = DEN_W + 1;
	localparam int Q_W = 17;

	// Pipeline stage numbering.
	localparam int DIV_FIRST = 14;
	localparam int DIV_LAST = DIV_FIRST + Q_W - 1;
	localparam int NS = DIV_LAST + 1;

	// Table build constants.
	localparam longint LN2_Q30 = 64'sh2C5C85FE;
	localparam u64_t MAGNUS_K = ((u64_t'(6112) << 30) + u64_t'(506625)) / u64_t'(1013250);

	typedef enum logic [1:0] {
		ST_OK,
		ST_CO2,
		ST_TEMP,
		ST_HUM
	} status_t;

	typedef enum logic [IDX_W-1:0] {
		REG_CO2_MIN,
		REG_CO2_MAX,
		REG_TEMP_MIN,
		REG_TEMP_MAX,
		REG_ALERT_THR
	} reg_index_t;

	// Side data that travels with each reading down the pipeline.
	typedef struct packed {
		status_t                   status;
		logic [CO2_W-1:0]          co2;
		logic signed [TEMP_W-1:0]  temp;
		logic [HUM_W-1:0]          hum;
	} meta_t;

	typedef logic [ROM_W-1:0] rom_table_t [TABLE_ENTRIES];

	// Unsigned quotient by shift and subtract, used only while the table is built.
	function automatic u64_t udiv64(u64_t nmr, u64_t dvs);
		u64_t quot;
		logic [64:0] rem;
		quot = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], nmr[b]};
			if (rem >= {1'b0, dvs}) begin
				rem = rem - {1'b0, dvs};
				quot[b] = 1'b1;
			end
		end
		return quot;
	endfunction

	// Signed quotient truncated toward zero; the divisor is positive.
	function automatic longint sdiv64(longint x, longint y);
		longint res;
		if (x < 0) begin
			res = -longint'(udiv64(u64_t'(-x), u64_t'(y)));
		end else begin
			res = longint'(udiv64(u64_t'(x), u64_t'(y)));
		end
		return res;
	endfunction

	// Saturation vapour pressure over 1013.25 hPa in Q24 at temperature t (0.01 C).
	function automatic logic [ROM_W-1:0] magnus_ratio_q24(longint t);
		longint a;
		longint n;
		longint r;
		longint s;
		u64_t sum;
		u64_t term;
		u64_t prod;
		logic [ROM_W-1:0] res;
		a = sdiv64(longint'(1762) * t * (longint'(1) << 30),
			longint'(100) * (longint'(24312) + t));
		n = sdiv64(a, LN2_Q30);
		r = a - n * LN2_Q30;
		if (r < 0) begin
			r = r + LN2_Q30;
			n = n - 1;
		end
		sum = u64_t'(1) << 30;
		term = u64_t'(1) << 30;
		for (int i = 1; i <= 24 && term != 0; i++) begin
			term = udiv64((term * u64_t'(r)) >> 30, u64_t'(i));
			sum = sum + term;
		end
		prod = MAGNUS_K * sum;
		s = 36 - n;
		if (s >= 63) begin
			res = '0;
		end else begin
			res = ROM_W'((prod + (u64_t'(1) << (s - 1))) >> s);
		end
		return res;
	endfunction

	// Whole table, node k at temperature -16384 + k * TSTEP.
	function automatic rom_table_t build_rom();
		rom_table_t tbl;
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			tbl[k] = magnus_ratio_q24(longint'(-16384) + longint'(k) * longint'(TSTEP));
		end
		return tbl;
	endfunction

endpackage

/* design/co2_dry_air_compensation_top.sv */
// Top level of the dry-air CO2 compensation pipeline.
// Depends on c2dc_pkg, c2dc_rom and c2dc_div.
//
// Channel   Handshake                 Payload
// input     in_valid / in_stall       co2_wet, temperature, humidity
// output    out_valid / out_stall     valid_res, status, co2_dry, alert,
//                                     temperature_out, humidity_out
// config    cfg_we                    cfg_index, cfg_data
//
// One reading enters per cycle unless in_stall holds it; its result reaches the output
// registers through every stage register. The 17-stage divider sets most of that depth.
// Reset clears the stage valid bits and loads the register defaults.
// Each stage moves whenever it is empty or the stage after it moves, so
// bubbles close up under an output stall and nothing is lost or repeated.
`timescale 1ns / 1ps

module co2_dry_air_compensation_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [c2dc_pkg::IDX_W-1:0]          cfg_index,
	input  logic [c2dc_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [c2dc_pkg::CO2_W-1:0]          co2_wet,
	input  logic signed [c2dc_pkg::TEMP_W-1:0]  temperature,
	input  logic [c2dc_pkg::HUM_W-1:0]          humidity,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                valid_res,
	output logic [1:0]                          status,
	output logic [c2dc_pkg::OUT_W-1:0]          co2_dry,
	output logic                                alert,
	output logic signed [c2dc_pkg::TEMP_W-1:0]  temperature_out,
	output logic [c2dc_pkg::HUM_W-1:0]          humidity_out
);
	import c2dc_pkg::*;

	// Configuration registers.
	logic [CO2_W-1:0]         co2_min_q;
	logic [CO2_W-1:0]         co2_max_q;
	logic signed [TEMP_W-1:0] temp_min_q;
	logic signed [TEMP_W-1:0] temp_max_q;
	logic [THR_W-1:0]         thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			co2_min_q  <= CO2_W'(0);
			co2_max_q  <= CO2_W'(400000);
			temp_min_q <= -TEMP_W'(4000);
			temp_max_q <= TEMP_W'(7000);
			thr_q      <= THR_W'(1000);
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_CO2_MIN:   co2_min_q  <= cfg_data;
				REG_CO2_MAX:   co2_max_q  <= cfg_data;
				REG_TEMP_MIN:  temp_min_q <= cfg_data[TEMP_W-1:0];
				REG_TEMP_MAX:  temp_max_q <= cfg_data[TEMP_W-1:0];
				REG_ALERT_THR: thr_q      <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage valid bits and the enable chain.
	logic [NS:1] vld_s;
	logic [NS:1] en;

	assign en[NS] = !vld_s[NS] || !out_stall;
	genvar k;
	for (k = 1; k < NS; k++) begin : g_en
		assign en[k] = !vld_s[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= in_valid;
			end
			for (int s = 2; s <= NS; s++) begin
				if (en[s]) begin
					vld_s[s] <= vld_s[s-1];
				end
			end
		end
	end

	assign in_stall = !en[1];
	assign out_valid = vld_s[NS];

	// Side data line.
	meta_t meta_s [1:NS-1];
	for (k = 2; k < NS; k++) begin : g_meta
		always_ff @(posedge clk) begin
			if (en[k]) begin
				meta_s[k] <= meta_s[k-1];
			end
		end
	end

	// Stage 1: range checks in priority order and table offset.
	status_t          st_in;
	logic [OFF_W-1:0] off_s1;

	always_comb begin
		priority if (co2_wet < co2_min_q || co2_wet > co2_max_q) begin
			st_in = ST_CO2;
		end else if (temperature < temp_min_q || temperature > temp_max_q) begin
			st_in = ST_TEMP;
		end else if (humidity > HUM_W'(HUM_MAX)) begin
			st_in = ST_HUM;
		end else begin
			st_in = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			meta_s[1] <= '{status: st_in, co2: co2_wet, temp: temperature, hum: humidity};
			off_s1 <= {~temperature[TEMP_W-1], temperature[TEMP_W-2:0]};
		end
	end

	// Stage 2: node index estimate by reciprocal.
	logic [TP_W-1:0]   tprod;
	logic [ADDR_W-1:0] iest_s2;
	logic [OFF_W-1:0]  off_s2;

	assign tprod = TP_W'(off_s1) * TP_W'(RECIP_T);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			iest_s2 <= tprod[T_SHIFT+ADDR_W-1:T_SHIFT];
			off_s2  <= off_s1;
		end
	end

	// Stage 3: correct the index, take the fraction, clamp at the last node.
	logic [F_W:0]      f0;
	logic              fix;
	logic [ADDR_W-1:0] idx;
	logic [F_W:0]      frac;
	logic              last;
	logic [ADDR_W-1:0] addr0_s3;
	logic [ADDR_W-1:0] addr1_s3;
	logic [F_W-1:0]    f_s3;

	assign f0 = (F_W+1)'(off_s2) - (F_W+1)'(iest_s2 * TSTEP);
	assign fix = f0 >= (F_W+1)'(TSTEP);
	assign idx = fix ? ADDR_W'(iest_s2 + 1'b1) : iest_s2;
	assign frac = fix ? (F_W+1)'(f0 - (F_W+1)'(TSTEP)) : f0;
	assign last = idx >= ADDR_W'(LAST_ENTRY);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			addr0_s3 <= last ? ADDR_W'(LAST_ENTRY) : idx;
			addr1_s3 <= last ? ADDR_W'(LAST_ENTRY) : ADDR_W'(idx + 1'b1);
			f_s3     <= last ? F_W'(0) : frac[F_W-1:0];
		end
	end

	// Stage 4: ROM read.
	logic [ROM_W-1:0] rom0_s4;
	logic [ROM_W-1:0] rom1_s4;
	logic [F_W-1:0]   f_s4;

	c2dc_rom u_rom (
		.clk   (clk),
		.en    (en[4]),
		.addr0 (addr0_s3),
		.addr1 (addr1_s3),
		.data0 (rom0_s4),
		.data1 (rom1_s4)
	);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			f_s4 <= f_s3;
		end
	end

	// Stage 5: slope times fraction plus half a step.
	logic [ROM_W-1:0] diff;
	logic [V_W-1:0]   v_s5;
	logic [ROM_W-1:0] rom0_s5;

	assign diff = rom1_s4 - rom0_s4;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			v_s5    <= V_W'(diff) * V_W'(f_s4) + V_W'(TSTEP_HALF);
			rom0_s5 <= rom0_s4;
		end
	end

	// Stage 6: partial products of the reciprocal multiply.
	logic [LO_W+ROM_W-1:0] pplo_s6;
	logic [HI_W+ROM_W-1:0] pphi_s6;
	logic [V_W-1:0]        v_s6;
	logic [ROM_W-1:0]      rom0_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			pplo_s6 <= (LO_W+ROM_W)'(v_s5[LO_W-1:0]) * (LO_W+ROM_W)'(RECIP_I);
			pphi_s6 <= (HI_W+ROM_W)'(v_s5[V_W-1:LO_W]) * (HI_W+ROM_W)'(RECIP_I);
			v_s6    <= v_s5;
			rom0_s6 <= rom0_s5;
		end
	end

	// Stage 7: sum the partial products into a quotient estimate.
	logic [SUM_W-1:0] isum;
	logic [ROM_W-1:0] iq0_s7;
	logic [R_W-1:0]   vlow_s7;
	logic [ROM_W-1:0] rom0_s7;

	assign isum = (SUM_W'(pphi_s6) << LO_W) + SUM_W'(pplo_s6);

	always_ff @(posedge clk) begin
		if (en[7]) begin
			iq0_s7  <= isum[S_I+ROM_W-1:S_I];
			vlow_s7 <= v_s6[R_W-1:0];
			rom0_s7 <= rom0_s6;
		end
	end

	// Stage 8: the estimate can be short by up to two; the remainder settles it.
	logic [R_W-1:0]   irem;
	logic [ROM_W-1:0] iq_s8;
	logic [ROM_W-1:0] rom0_s8;

	assign irem = vlow_s7 - R_W'(iq0_s7 * TSTEP);

	always_ff @(posedge clk) begin
		if (en[8]) begin
			priority if (irem >= R_W'(2 * TSTEP)) begin
				iq_s8 <= iq0_s7 + ROM_W'(2);
			end else if (irem >= R_W'(TSTEP)) begin
				iq_s8 <= iq0_s7 + ROM_W'(1);
			end else begin
				iq_s8 <= iq0_s7;
			end
			rom0_s8 <= rom0_s7;
		end
	end

	// Stage 9: interpolated ratio.
	logic [ROM_W-1:0] x_s9;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			x_s9 <= rom0_s8 + iq_s8;
		end
	end

	// Stage 10: scale by humidity, with the rounding offset.
	logic [P_W-1:0] p_s10;

	always_ff @(posedge clk) begin
		if (en[10]) begin
			p_s10 <= P_W'(x_s9) * P_W'(meta_s[9].hum) + P_W'(HUM_HALF);
		end
	end

	// Stage 11: clamp test and divide by 10000 as a shift and a reciprocal.
	logic [MP_W-1:0] mprod;
	logic            sat_s11;
	logic [Y_W-1:0]  y_s11;
	logic [M_W-1:0]  mq0_s11;

	assign mprod = MP_W'(p_s10[Y_W+3:4]) * MP_W'(RECIP_M);

	always_ff @(posedge clk) begin
		if (en[11]) begin
			sat_s11 <= p_s10 >= P_W'(SAT_LIM);
			y_s11   <= p_s10[Y_W+3:4];
			mq0_s11 <= mprod[M_SHIFT+M_W-1:M_SHIFT];
		end
	end

	// Stage 12: correct the mole fraction estimate and apply the clamp.
	logic [MR_W-1:0] mrem;
	logic [M_W-1:0]  m_s12;

	assign mrem = y_s11[MR_W-1:0] - MR_W'(mq0_s11 * M_DIV);

	always_ff @(posedge clk) begin
		if (en[12]) begin
			if (sat_s11) begin
				m_s12 <= M_W'(XMAX_Q24);
			end else if (mrem >= MR_W'(M_DIV)) begin
				m_s12 <= mq0_s11 + M_W'(1);
			end else begin
				m_s12 <= mq0_s11;
			end
		end
	end

	// Stage 13: divider operands, rounded quotient as floor((2n + d) / 2d).
	logic [DEN_W-1:0] den;
	logic [N_W-1:0]   num_s13;
	logic [D_W-1:0]   dsr_s13;

	assign den = DEN_W'(10 * (25'(ONE_Q24) - 25'(m_s12)));

	always_ff @(posedge clk) begin
		if (en[13]) begin
			num_s13 <= N_W'({meta_s[12].co2, 25'b0}) + N_W'(den);
			dsr_s13 <= {den, 1'b0};
		end
	end

	// Stages 14 to 30: divider.
	logic [Q_W-1:0] quo;

	c2dc_div u_div (
		.clk (clk),
		.en  (en[DIV_LAST:DIV_FIRST]),
		.num (num_s13),
		.dsr (dsr_s13),
		.quo (quo)
	);

	// Output stage: saturate, compare with the threshold, zero a rejected reading.
	logic [OUT_W-1:0] qsat;
	meta_t            mo;

	assign mo = meta_s[DIV_LAST];
	assign qsat = (quo > Q_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : quo[OUT_W-1:0];

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			status <= 2'(mo.status);
			if (mo.status == ST_OK) begin
				valid_res       <= 1'b1;
				co2_dry         <= qsat;
				alert           <= qsat > thr_q;
				temperature_out <= mo.temp;
				humidity_out    <= mo.hum;
			end else begin
				valid_res       <= 1'b0;
				co2_dry         <= '0;
				alert           <= 1'b0;
				temperature_out <= '0;
				humidity_out    <= '0;
			end
		end
	end

endmodule

/* design/c2dc_rom.sv */
// Constant vapour ratio ROM with two registered read ports.
// Depends on c2dc_pkg for the table geometry and the table builder.
`timescale 1ns / 1ps

module c2dc_rom (
	input  logic                        clk,
	input  logic                        en,
	input  logic [c2dc_pkg::ADDR_W-1:0] addr0,
	input  logic [c2dc_pkg::ADDR_W-1:0] addr1,
	output logic [c2dc_pkg::ROM_W-1:0]  data0,
	output logic [c2dc_pkg::ROM_W-1:0]  data1
);
	import c2dc_pkg::*;

	localparam rom_table_t ROM_TABLE = build_rom();

	// Both neighbor nodes are read together; the data holds while the stage stalls.
	always_ff @(posedge clk) begin
		if (en) begin
			data0 <= ROM_TABLE[addr0];
			data1 <= ROM_TABLE[addr1];
		end
	end

endmodule

/* design/c2dc_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on c2dc_pkg for operand widths; stage enables come from the top level.
`timescale 1ns / 1ps

module c2dc_div (
	input  logic                      clk,
	input  logic [c2dc_pkg::Q_W-1:0]  en,
	input  logic [c2dc_pkg::N_W-1:0]  num,
	input  logic [c2dc_pkg::D_W-1:0]  dsr,
	output logic [c2dc_pkg::Q_W-1:0]  quo
);
	import c2dc_pkg::*;

	logic [N_W-1:0] rem_s [Q_W];
	logic [D_W-1:0] dsr_s [Q_W];
	logic [Q_W-1:0] quo_s [Q_W];

	genvar j;
	for (j = 0; j < Q_W; j++) begin : g_stage
		localparam int BIT = Q_W - 1 - j;
		logic [N_W-1:0] rem_in;
		logic [D_W-1:0] dsr_in;
		logic [Q_W-1:0] quo_in;
		logic [N_W:0]   trial;
		logic           fits;

		if (j == 0) begin : g_first
			assign rem_in = num;
			assign dsr_in = dsr;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign dsr_in = dsr_s[j-1];
			assign quo_in = quo_s[j-1];
		end

		// Try to take the shifted divisor out of the partial remainder.
		assign trial = (N_W+1)'(dsr_in) << BIT;
		assign fits = {1'b0, rem_in} >= trial;

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_s[j] <= fits ? N_W'({1'b0, rem_in} - trial) : rem_in;
				dsr_s[j] <= dsr_in;
				quo_s[j] <= fits ? (quo_in | (Q_W'(1) << BIT)) : quo_in;
			end
		end
	end

	assign quo = quo_s[Q_W-1];

endmodule

/* tb/co2_dry_air_compensation_top_tb.sv */
// Self-checking testbench for the dry-air CO2 compensation pipeline.
// Depends on c2dc_pkg and co2_dry_air_compensation_top; predicts every result internally.
`timescale 1ns / 1ps

module co2_dry_air_compensation_top_tb;
	import c2dc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;
	localparam longint LN2_FIX = 64'h2C5C85FE;

	typedef struct {
		logic [CO2_W-1:0]         co2;
		logic signed [TEMP_W-1:0] temp;
		logic [HUM_W-1:0]         hum;
	} reading_t;

	typedef struct {
		logic                     ok;
		logic [1:0]               st;
		logic [OUT_W-1:0]         dry;
		logic                     al;
		logic signed [TEMP_W-1:0] tout;
		logic [HUM_W-1:0]         hout;
	} dry_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CO2_W-1:0] co2_wet = '0;
	logic signed [TEMP_W-1:0] temperature = '0;
	logic [HUM_W-1:0] humidity = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic valid_res;
	logic [1:0] status;
	logic [OUT_W-1:0] co2_dry;
	logic alert;
	logic signed [TEMP_W-1:0] temperature_out;
	logic [HUM_W-1:0] humidity_out;

	// Shadow copy of the configuration registers.
	logic [CO2_W-1:0] win_co2_lo = 0;
	logic [CO2_W-1:0] win_co2_hi = 400000;
	logic signed [TEMP_W-1:0] win_temp_lo = -4000;
	logic signed [TEMP_W-1:0] win_temp_hi = 7000;
	logic [THR_W-1:0] alert_level = 1000;

	logic [31:0] vapor_rom [TABLE_ENTRIES];
	reading_t pending_readings[$];
	dry_result_t due_results[$];
	int error_count = 0;
	int idle_cycles = 0;
	bit hold_sender = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_cnt = 0;
	int stall_mode = 0;

	co2_dry_air_compensation_top i_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Vapor pressure ratio in Q24 by the Magnus formula, integer arithmetic only.
	function automatic logic [31:0] vapor_ratio(longint t);
		longint a, n, r, s;
		longint unsigned kc, sum, term, prod;
		a = (64'sd1762 * t * (64'sd1 << 30)) / (64'sd100 * (64'sd24312 + t));
		n = a / LN2_FIX;
		r = a - n * LN2_FIX;
		if (r < 0) begin
			r = r + LN2_FIX;
			n = n - 1;
		end
		kc = ((64'd6112 << 30) + 64'd506625) / 64'd1013250;
		sum = 64'd1 << 30;
		term = 64'd1 << 30;
		for (int i = 1; i <= 24; i++) begin
			term = ((term * longint'(r)) >> 30) / longint'(i);
			sum = sum + term;
		end
		prod = kc * sum;
		s = 36 - n;
		if (s >= 63)
			return 32'd0;
		return 32'((prod + (64'd1 << (s - 1))) >> s);
	endfunction

	// Expected result of one reading under the current register settings.
	function automatic dry_result_t predict_reading(reading_t rd);
		dry_result_t res;
		longint unsigned x, m, den, num, q, lo, hi;
		int off, idx, frac;
		res = '{ok: 1'b0, st: ST_OK, dry: '0, al: 1'b0, tout: '0, hout: '0};
		if (rd.co2 < win_co2_lo || rd.co2 > win_co2_hi)
			res.st = ST_CO2;
		else if (rd.temp < win_temp_lo || rd.temp > win_temp_hi)
			res.st = ST_TEMP;
		else if (rd.hum > HUM_MAX)
			res.st = ST_HUM;
		if (res.st != ST_OK)
			return res;
		off = int'(rd.temp) + 16384;
		idx = off / TSTEP;
		frac = off % TSTEP;
		if (idx >= TABLE_ENTRIES - 1) begin
			x = vapor_rom[TABLE_ENTRIES - 1];
		end else begin
			lo = vapor_rom[idx];
			hi = vapor_rom[idx + 1];
			x = lo + ((longint'(32'(hi - lo)) * frac + TSTEP / 2) / TSTEP);
		end
		m = (x * rd.hum + 5000) / 10000;
		if (m > XMAX_Q24)
			m = XMAX_Q24;
		den = 10 * ((64'd1 << 24) - m);
		num = longint'(rd.co2) << 24;
		q = (2 * num + den) / (2 * den);
		if (q > OUT_MAX)
			q = OUT_MAX;
		res.ok = 1'b1;
		res.dry = OUT_W'(q);
		res.al = (q > alert_level);
		res.tout = rd.temp;
		res.hout = rd.hum;
		return res;
	endfunction

	// Random reading, mostly inside the sensor range with some full-width noise.
	function automatic reading_t random_reading();
		reading_t rd;
		rd.co2 = ($urandom_range(0, 9) == 0) ? CO2_W'($urandom) : CO2_W'($urandom_range(0, 400000));
		if ($urandom_range(0, 7) == 0)
			rd.temp = TEMP_W'($urandom);
		else
			rd.temp = TEMP_W'(int'($urandom_range(0, 12700)) - 4000);
		rd.hum = ($urandom_range(0, 7) == 0) ? HUM_W'($urandom) : HUM_W'($urandom_range(0, 10000));
		return rd;
	endfunction

	task automatic write_reg(reg_index_t idx, int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= (idx == REG_TEMP_MIN || idx == REG_TEMP_MAX) ? CFG_W'(value & 16'h7FFF)
			: CFG_W'(value);
		case (idx)
			REG_CO2_MIN: win_co2_lo = CO2_W'(value);
			REG_CO2_MAX: win_co2_hi = CO2_W'(value);
			REG_TEMP_MIN: win_temp_lo = TEMP_W'(value);
			REG_TEMP_MAX: win_temp_hi = TEMP_W'(value);
			default: alert_level = THR_W'(value);
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_reading(int c, int t, int h);
		reading_t rd;
		rd.co2 = CO2_W'(c);
		rd.temp = TEMP_W'(t);
		rd.hum = HUM_W'(h);
		pending_readings.push_back(rd);
	endtask

	task automatic push_random(int count);
		for (int k = 0; k < count; k++)
			pending_readings.push_back(random_reading());
	endtask

	// Wait until every reading is sent and every result is back, then let the pipe drain.
	task automatic wait_idle();
		while (pending_readings.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Driver: presents queued readings in bursts separated by random gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				due_results.push_back(predict_reading('{co2_wet, temperature, humidity}));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (!hold_sender && pending_readings.size() != 0) begin
					reading_t rd;
					rd = pending_readings.pop_front();
					co2_wet <= rd.co2;
					temperature <= rd.temp;
					humidity <= rd.hum;
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall pattern: one of four modes, redrawn at random from time to time.
	always @(posedge clk) begin
		stall_cnt++;
		if (stall_cnt % 64 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			2: out_stall <= (stall_cnt % 8) < 5;
			default: out_stall <= ($urandom_range(0, 9) == 0);
		endcase
	end

	// Monitor and watchdog.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("co2_dry_air_compensation_top_tb NOT OK");
			$finish;
		end else if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result transaction", $time);
				error_count++;
			end else begin
				dry_result_t e;
				e = due_results.pop_front();
				if (valid_res !== e.ok) begin
					$display("%0t: valid_res exp %0d got %0d", $time, e.ok, valid_res);
					error_count++;
				end
				if (status !== e.st) begin
					$display("%0t: status exp %0d got %0d", $time, e.st, status);
					error_count++;
				end
				if (co2_dry !== e.dry) begin
					$display("%0t: co2_dry exp %0d got %0d", $time, e.dry, co2_dry);
					error_count++;
				end
				if (alert !== e.al) begin
					$display("%0t: alert exp %0d got %0d", $time, e.al, alert);
					error_count++;
				end
				if (temperature_out !== e.tout) begin
					$display("%0t: temperature_out exp %0d got %0d", $time, e.tout,
						temperature_out);
					error_count++;
				end
				if (humidity_out !== e.hout) begin
					$display("%0t: humidity_out exp %0d got %0d", $time, e.hout, humidity_out);
					error_count++;
				end
			end
		end
	end

	// Stimulus phases, each under its own register settings.
	initial begin
		for (int k = 0; k < TABLE_ENTRIES; k++)
			vapor_rom[k] = vapor_ratio(-16384 + k * TSTEP);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults: field extremes and the order of the range checks.
		push_reading(0, 2500, 5000);
		push_reading(400000, 7000, 10000);
		push_reading(524287, 2500, 5000);
		push_reading(400000, -4000, 0);
		push_reading(10000, 7001, 5000);
		push_reading(10000, -4001, 5000);
		push_reading(10000, -16384, 5000);
		push_reading(10000, 16383, 5000);
		push_reading(10000, 2500, 10001);
		push_reading(10000, 2500, 16383);
		push_reading(524287, 16383, 16383);
		push_reading(10000, 12500, 16383);
		push_reading(10000, 2000, 0);
		push_reading(9990, 2000, 0);
		push_reading(10010, 2000, 0);
		push_reading(10005, 2000, 0);
		push_reading(9995, 2000, 0);
		push_reading(350000, 6900, 9999);
		push_reading(1, 0, 1);
		push_random(400);
		wait_idle();

		// Widest windows and a zero alert threshold, with one full drain midway.
		write_reg(REG_CO2_MIN, 0);
		write_reg(REG_CO2_MAX, 400000);
		write_reg(REG_TEMP_MIN, -4000);
		write_reg(REG_TEMP_MAX, 8700);
		write_reg(REG_ALERT_THR, 0);
		push_reading(0, 8700, 10000);
		push_reading(400000, 8700, 10000);
		push_reading(5, 8701, 10000);
		push_random(200);
		while (pending_readings.size() > 100)
			@(posedge clk);
		hold_sender = 1'b1;
		while (in_valid || due_results.size() != 0)
			@(posedge clk);
		hold_sender = 1'b0;
		push_random(200);
		wait_idle();

		// Crossed windows reject everything; highest alert threshold.
		write_reg(REG_CO2_MIN, 400000);
		write_reg(REG_CO2_MAX, 0);
		write_reg(REG_TEMP_MIN, 8700);
		write_reg(REG_TEMP_MAX, -4000);
		write_reg(REG_ALERT_THR, 65535);
		push_random(100);
		wait_idle();

		// Only the temperature window crossed.
		write_reg(REG_CO2_MIN, 0);
		write_reg(REG_CO2_MAX, 400000);
		push_random(100);
		wait_idle();

		// Random settings in several rounds.
		for (int p = 0; p < 5; p++) begin
			write_reg(REG_CO2_MIN, $urandom_range(0, 100000));
			write_reg(REG_CO2_MAX, $urandom_range(300000, 400000));
			write_reg(REG_TEMP_MIN, int'($urandom_range(0, 6000)) - 4000);
			write_reg(REG_TEMP_MAX, int'($urandom_range(4000, 12700)) - 4000);
			write_reg(REG_ALERT_THR, $urandom_range(0, 5000));
			push_random(170);
			wait_idle();
		end

		if (error_count == 0)
			$display("co2_dry_air_compensation_top_tb OK");
		else
			$display("co2_dry_air_compensation_top_tb NOT OK");
		$finish;
	end

endmodule

/* sim.f */
design/c2dc_pkg.sv
design/c2dc_rom.sv
design/c2dc_div.sv
design/co2_dry_air_compensation_top.sv
tb/co2_dry_air_compensation_top_tb.sv
